// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sorted priority queue: request and status codes, entry type.
// No dependencies.
package spq_pkg;
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_POP_TOP = 2'd1;
  localparam logic [1:0] REQ_POP_EQ  = 2'd2;
  localparam logic [1:0] REQ_POP_GE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         prio;
  } entry_t;
endpackage

// ----- hdl/spq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// No dependencies.
interface spq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] item_data;
  logic [7:0]         item_priority;
  modport source (output valid, req_type, item_data, item_priority, input ready);
  modport sink (input valid, req_type, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if #(parameter int CNT_W = 5);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_data;
  logic [CNT_W-1:0]   entry_count;
  modport source (output valid, status, out_data, entry_count, input ready);
  modport sink (input valid, status, out_data, entry_count, output ready);
endinterface

// ----- hdl/spq_mem.sv -----
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
// Depends on spq_pkg.
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spq_pkg::entry_t rdata
);
  spq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// Sorted priority queue, entries held in one memory in descending priority.
// Each request scans entries in order through the registered memory read port,
// then shifts entries one per read/write step. One request at a time.
// Result held in an output register.
// Reset: synchronous active-low rst_n empties the queue; store is not cleared.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic     clk,
  input logic     rst_n,
  spq_req_if.sink in_ch,
  spq_rsp_if.source out_ch
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         req_r, req_nxt;
  logic signed [31:0] dat_r, dat_nxt;
  logic [7:0]         pri_r, pri_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;     // address being read this cycle
  logic               rd_v_r, rd_v_nxt;   // read issued last cycle
  logic [CW-1:0]      ridx_r, ridx_nxt;   // address of rdata
  logic [CW-1:0]      pos_r, pos_nxt;     // target slot
  logic [CW-1:0]      end_r, end_nxt;
  logic               hit_r, hit_nxt;     // removal pending
  logic [1:0]         st_r, st_nxt;
  logic signed [31:0] res_r, res_nxt;
  spq_pkg::entry_t    prev_r, prev_nxt;
  logic               ov_r, ov_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  spq_pkg::entry_t    wdata, rdata;

  spq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE) && (!ov_r || out_ch.ready);
  assign out_ch.valid       = ov_r;
  assign out_ch.status      = st_r;
  assign out_ch.out_data    = res_r;
  assign out_ch.entry_count = cnt_r;
  assign raddr              = (state_r == S_IDLE) ? '0 : idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; req_nxt = req_r; dat_nxt = dat_r;
    pri_nxt = pri_r; idx_nxt = idx_r; rd_v_nxt = 1'b0; ridx_nxt = idx_r;
    pos_nxt = pos_r; end_nxt = end_r; hit_nxt = hit_r; st_nxt = st_r;
    res_nxt = res_r; prev_nxt = prev_r; ov_nxt = ov_r;
    we = 1'b0; waddr = '0; wdata = '0;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          req_nxt = in_ch.req_type; dat_nxt = in_ch.item_data;
          pri_nxt = in_ch.item_priority; res_nxt = '0; st_nxt = spq_pkg::ST_OK;
          idx_nxt = '0; hit_nxt = 1'b0;
          if (in_ch.req_type == spq_pkg::REQ_INSERT) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              st_nxt = spq_pkg::ST_FULL; state_nxt = S_OUT;
            end else if (cnt_r == '0) begin
              pos_nxt = '0; state_nxt = S_DONE;
            end else begin
              // scan for first entry below new priority
              idx_nxt = CW'(1); rd_v_nxt = 1'b1; ridx_nxt = '0; pos_nxt = cnt_r;
              state_nxt = S_SCAN;
            end
          end else if (cnt_r == '0) begin
            st_nxt = spq_pkg::ST_EMPTY; state_nxt = S_OUT;
          end else begin
            idx_nxt = CW'(1); rd_v_nxt = 1'b1; ridx_nxt = '0; state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rdata holds entry ridx_r
        idx_nxt = idx_r + CW'(1); rd_v_nxt = 1'b1; ridx_nxt = idx_r;
        prev_nxt = rdata;
        if (req_r == spq_pkg::REQ_INSERT) begin
          if (rdata.prio < pri_r) begin
            pos_nxt = ridx_r; state_nxt = S_DONE;
          end else if (ridx_r + CW'(1) == cnt_r) begin
            pos_nxt = cnt_r; state_nxt = S_DONE;
          end
        end else begin
          if (req_r == spq_pkg::REQ_POP_TOP || rdata.prio == pri_r) begin
            res_nxt = rdata.data; pos_nxt = ridx_r; hit_nxt = 1'b1;
          end else if (req_r == spq_pkg::REQ_POP_GE && rdata.prio < pri_r) begin
            if (ridx_r == '0) begin
              st_nxt = spq_pkg::ST_NOMATCH; state_nxt = S_OUT;
            end else begin
              res_nxt = prev_r.data; pos_nxt = ridx_r - CW'(1); hit_nxt = 1'b1;
            end
          end else if (ridx_r + CW'(1) == cnt_r) begin
            if (req_r == spq_pkg::REQ_POP_GE) begin
              res_nxt = rdata.data; pos_nxt = ridx_r; hit_nxt = 1'b1;
            end else begin
              st_nxt = spq_pkg::ST_NOMATCH; state_nxt = S_OUT;
            end
          end
          if (hit_nxt) begin
            // shift entries after pos down by one
            idx_nxt = pos_nxt + CW'(1); rd_v_nxt = 1'b0; state_nxt = S_SHIFT;
          end
        end
        if (req_r == spq_pkg::REQ_INSERT && state_nxt == S_DONE) begin
          // shift entries pos..cnt-1 up, from the tail
          end_nxt = pos_nxt; idx_nxt = cnt_r - CW'(1); rd_v_nxt = 1'b0;
          state_nxt = (pos_nxt == cnt_r) ? S_DONE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        rd_v_nxt = 1'b1; ridx_nxt = idx_r;
        if (req_r == spq_pkg::REQ_INSERT) begin
          if (rd_v_r) begin
            we = 1'b1; waddr = AW'(ridx_r + CW'(1)); wdata = rdata;
            rd_v_nxt = 1'b0;
            if (ridx_r == end_r) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt = ridx_r - CW'(1);
            end
          end
        end else begin
          if (rd_v_r) begin
            we = 1'b1; waddr = AW'(ridx_r - CW'(1)); wdata = rdata;
            rd_v_nxt = 1'b0; idx_nxt = ridx_r + CW'(1);
          end
          if ((rd_v_r ? ridx_r + CW'(1) : idx_r) >= cnt_r) begin
            rd_v_nxt = 1'b0; cnt_nxt = cnt_r - CW'(1); state_nxt = S_OUT;
          end
        end
      end
      S_DONE: begin
        we = 1'b1; waddr = AW'(pos_r); wdata = '{data: dat_r, prio: pri_r};
        cnt_nxt = cnt_r + CW'(1); state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0; rd_v_r <= 1'b0; hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; rd_v_r <= rd_v_nxt;
      hit_r <= hit_nxt;
    end
    req_r <= req_nxt; dat_r <= dat_nxt; pri_r <= pri_nxt; idx_r <= idx_nxt;
    ridx_r <= ridx_nxt; pos_r <= pos_nxt; end_r <= end_nxt; st_r <= st_nxt;
    res_r <= res_nxt; prev_r <= prev_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("count overflow");
  a_full_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == spq_pkg::ST_FULL |->
    out_ch.entry_count == CW'(QUEUE_DEPTH)) else $error("full status wrong");
  a_empty_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == spq_pkg::ST_EMPTY |-> out_ch.entry_count == '0)
    else $error("empty status wrong");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
endmodule
